>>> hdl/hps_pkg.sv
package hps_pkg;

   // item mode codes
   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_TRIGGER = 1'b1;

   // pattern codes
   localparam logic [2:0] PAT_NONE   = 3'd0;
   localparam logic [2:0] PAT_TOGGLE = 3'd1;
   localparam logic [2:0] PAT_LOW    = 3'd2;
   localparam logic [2:0] PAT_BUILD  = 3'd3;
   localparam logic [2:0] PAT_HIGH   = 3'd4;

   // step phase codes
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_RAMP  = 2'd1;
   localparam logic [1:0] PH_UP    = 2'd2;
   localparam logic [1:0] PH_DOWN  = 2'd3;

   // ramp table size, 2 to 128
   localparam int RAMP_BASE  = 16;
   localparam int RAMP_IDX_W = (RAMP_BASE > 1) ? $clog2(RAMP_BASE) : 1;
   localparam logic [7:0] RAMP_LIMIT = 8'(RAMP_BASE);

   // levels
   localparam logic [7:0] LEVEL_FLOOR   = 8'd75;
   localparam logic [7:0] LEVEL_TOGGLE  = 8'd200;
   localparam logic [7:0] LEVEL_UP_BASE = 8'd125;
   localparam logic [7:0] LEVEL_UP_TOP  = 8'd245;
   localparam logic [7:0] LEVEL_MAX     = 8'd255;
   localparam logic [7:0] LEVEL_LOW_END = 8'd100;
   localparam logic [7:0] LEVEL_BLD_END = 8'd145;
   localparam logic [7:0] LEVEL_PULSE   = 8'd150;
   localparam logic [7:0] LEVEL_HP_END  = 8'd10;
   localparam logic [7:0] STEP_10       = 8'd10;
   localparam logic [7:0] STEP_15       = 8'd15;

   // hold times, stored as ticks minus one
   localparam logic [6:0] HOLD_TOGGLE   = 7'd49;
   localparam logic [6:0] HOLD_LOW_RAMP = 7'd19;
   localparam logic [6:0] HOLD_LOW_UP   = 7'd14;
   localparam logic [6:0] HOLD_LOW_DN   = 7'd9;
   localparam logic [6:0] HOLD_BLD_RAMP = 7'd99;
   localparam logic [6:0] HOLD_BLD_STEP = 7'd24;
   localparam logic [6:0] HOLD_PULSE    = 7'd57;
   localparam logic [6:0] HOLD_HP_DN    = 7'd49;

   // pulses per burst and bursts per high-power run
   localparam logic [1:0] PULSES_PER_BURST = 2'd3;
   localparam logic [2:0] BURSTS           = 3'd5;

   typedef logic [7:0] ramp_table_type [RAMP_BASE];

   // ceil(255 * i / RAMP_BASE), evaluated at elaboration
   function automatic ramp_table_type build_ramp();
      ramp_table_type t;
      for (int i = 0; i < RAMP_BASE; i++) begin
         t[i] = 8'((255 * i + RAMP_BASE - 1) / RAMP_BASE);
      end
      return t;
   endfunction

   localparam ramp_table_type RAMP_TABLE = build_ramp();

   typedef struct packed {
      logic       mode;
      logic [2:0] pattern;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [7:0] drive_level;
      logic [2:0] pattern_now;
      logic       trigger_taken;
   } rsp_type;

endpackage

>>> hdl/haptic_pattern_sequencer.sv
// channel   | direction | handshake             | payload
// req_      | in        | req_valid / req_ready | req_data (mode, pattern, restart)
// rsp_      | out       | rsp_valid / rsp_ready | rsp_data (drive_level, pattern_now,
//           |           |                       |           trigger_taken)
// csr_      | in        | csr_valid / csr_ready | csr_data (allow_low_levels)
//
// One item per cycle while rsp_ready does not stall: the step machine updates and the
// result register loads in the cycle the item transfers; the result is valid the cycle after.
// The result register is the only stage, so req_ready is high while it is empty or
// being drained in the same cycle.
// Reset (synchronous) clears the pattern state, the clamp enable and rsp_valid.
// csr_ready is always high.
module haptic_pattern_sequencer
   import hps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic       allow_low_ff;
   logic [2:0] active_ff, active_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] loop_ff, loop_in;
   logic [2:0] burst_ff, burst_in;
   logic [1:0] pulse_ff, pulse_in;
   logic       tbit_ff, tbit_in;
   logic [6:0] wait_ff, wait_in;
   logic [7:0] level_ff, level_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       req_xfer;
   logic [2:0] trig_pat;
   logic       taken;
   logic       do_emit;
   logic       do_finish;
   logic [7:0] emit_val;
   logic [6:0] emit_hold;
   logic [7:0] lv_inc, lv_up10, lv_dn10, lv_dn15;
   logic [1:0] pc_inc;
   logic [2:0] bc_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign trig_pat = (req_data.pattern > PAT_HIGH) ? PAT_NONE : req_data.pattern;
   assign lv_inc   = loop_ff + 8'd1;
   assign lv_up10  = loop_ff + STEP_10;
   assign lv_dn10  = loop_ff - STEP_10;
   assign lv_dn15  = loop_ff - STEP_15;
   assign pc_inc   = pulse_ff + 2'd1;
   assign bc_inc   = burst_ff + 3'd1;

   // step machine
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      loop_in   = loop_ff;
      burst_in  = burst_ff;
      pulse_in  = pulse_ff;
      tbit_in   = tbit_ff;
      wait_in   = wait_ff;
      level_in  = level_ff;
      taken     = 1'b0;
      do_emit   = 1'b0;
      do_finish = 1'b0;
      emit_val  = '0;
      emit_hold = '0;

      if (req_data.mode == MODE_TRIGGER) begin
         // trigger: select pattern, restart if changed or asked
         if (trig_pat == PAT_TOGGLE) begin
            loop_in = '0;
         end
         taken     = (active_ff != trig_pat) || req_data.restart;
         active_in = trig_pat;
         if (taken) begin
            level_in = '0;
            phase_in = PH_START;
            wait_in  = '0;
         end
      end else if (active_ff != PAT_NONE) begin
         if (wait_ff != '0) begin
            wait_in = wait_ff - 7'd1;
         end else begin
            case (active_ff)
               PAT_TOGGLE: begin
                  do_emit   = 1'b1;
                  emit_hold = HOLD_TOGGLE;
                  if (loop_ff == '0) begin
                     loop_in  = 8'd1;
                     emit_val = '0;
                  end else begin
                     loop_in  = '0;
                     emit_val = LEVEL_TOGGLE;
                  end
               end
               PAT_LOW, PAT_BUILD: begin
                  case (phase_ff)
                     PH_START: begin
                        loop_in   = '0;
                        phase_in  = PH_RAMP;
                        do_emit   = 1'b1;
                        emit_val  = RAMP_TABLE[0];
                        emit_hold = (active_ff == PAT_BUILD) ? HOLD_BLD_RAMP : HOLD_LOW_RAMP;
                     end
                     PH_RAMP: begin
                        do_emit = 1'b1;
                        if (lv_inc < RAMP_LIMIT) begin
                           loop_in   = lv_inc;
                           emit_val  = RAMP_TABLE[lv_inc[RAMP_IDX_W-1:0]];
                           emit_hold = (active_ff == PAT_BUILD) ? HOLD_BLD_RAMP
                                                                : HOLD_LOW_RAMP;
                        end else begin
                           loop_in   = LEVEL_UP_BASE;
                           phase_in  = PH_UP;
                           emit_val  = LEVEL_UP_BASE;
                           emit_hold = (active_ff == PAT_BUILD) ? HOLD_BLD_STEP : HOLD_LOW_UP;
                        end
                     end
                     PH_UP: begin
                        do_emit = 1'b1;
                        if (lv_up10 <= LEVEL_UP_TOP) begin
                           loop_in   = lv_up10;
                           emit_val  = lv_up10;
                           emit_hold = (active_ff == PAT_BUILD) ? HOLD_BLD_STEP : HOLD_LOW_UP;
                        end else begin
                           loop_in   = LEVEL_MAX;
                           phase_in  = PH_DOWN;
                           emit_val  = LEVEL_MAX;
                           emit_hold = (active_ff == PAT_BUILD) ? HOLD_BLD_STEP : HOLD_LOW_DN;
                        end
                     end
                     default: begin
                        // falling leg: build loops back, low power ends
                        if (active_ff == PAT_BUILD) begin
                           do_emit   = 1'b1;
                           emit_hold = HOLD_BLD_STEP;
                           if (lv_dn10 >= LEVEL_BLD_END) begin
                              loop_in  = lv_dn10;
                              emit_val = lv_dn10;
                           end else begin
                              loop_in  = LEVEL_UP_BASE;
                              phase_in = PH_UP;
                              emit_val = LEVEL_UP_BASE;
                           end
                        end else begin
                           loop_in = lv_dn15;
                           if (lv_dn15 > LEVEL_LOW_END) begin
                              do_emit   = 1'b1;
                              emit_val  = lv_dn15;
                              emit_hold = HOLD_LOW_DN;
                           end else begin
                              do_finish = 1'b1;
                           end
                        end
                     end
                  endcase
               end
               PAT_HIGH: begin
                  case (phase_ff)
                     PH_START: begin
                        burst_in  = '0;
                        pulse_in  = '0;
                        phase_in  = PH_RAMP;
                        tbit_in   = 1'b1;
                        do_emit   = 1'b1;
                        emit_val  = LEVEL_PULSE;
                        emit_hold = HOLD_PULSE;
                     end
                     PH_RAMP: begin
                        do_emit = 1'b1;
                        if (pc_inc < PULSES_PER_BURST) begin
                           // next pulse of the burst alternates 150 and 255
                           pulse_in  = pc_inc;
                           tbit_in   = !tbit_ff;
                           emit_val  = tbit_ff ? LEVEL_MAX : LEVEL_PULSE;
                           emit_hold = HOLD_PULSE;
                        end else begin
                           pulse_in = '0;
                           burst_in = bc_inc;
                           if (bc_inc < BURSTS) begin
                              tbit_in   = 1'b1;
                              emit_val  = LEVEL_PULSE;
                              emit_hold = HOLD_PULSE;
                           end else begin
                              loop_in   = LEVEL_MAX;
                              phase_in  = PH_UP;
                              emit_val  = LEVEL_MAX;
                              emit_hold = HOLD_HP_DN;
                           end
                        end
                     end
                     PH_UP: begin
                        loop_in = lv_dn10;
                        if (lv_dn10 >= LEVEL_HP_END) begin
                           do_emit   = 1'b1;
                           emit_val  = lv_dn10;
                           emit_hold = HOLD_HP_DN;
                        end else begin
                           do_finish = 1'b1;
                        end
                     end
                     default: do_finish = 1'b1;
                  endcase
               end
               default: ;
            endcase
         end
      end

      // new level with dead-zone clamp
      if (do_emit) begin
         wait_in = emit_hold;
         if (emit_val != '0 && emit_val < LEVEL_FLOOR && !allow_low_ff) begin
            level_in = LEVEL_FLOOR;
         end else begin
            level_in = emit_val;
         end
      end

      // one-shot pattern end
      if (do_finish) begin
         active_in = PAT_NONE;
         phase_in  = PH_START;
         wait_in   = '0;
         level_in  = '0;
      end

      rsp_data_in.drive_level   = level_in;
      rsp_data_in.pattern_now   = active_in;
      rsp_data_in.trigger_taken = taken;
   end

   // state and clamp enable
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_low_ff <= 1'b0;
         active_ff    <= PAT_NONE;
         phase_ff     <= PH_START;
         loop_ff      <= '0;
         burst_ff     <= '0;
         pulse_ff     <= '0;
         tbit_ff      <= 1'b0;
         wait_ff      <= '0;
         level_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            allow_low_ff <= csr_data;
         end
         if (req_xfer) begin
            active_ff <= active_in;
            phase_ff  <= phase_in;
            loop_ff   <= loop_in;
            burst_ff  <= burst_in;
            pulse_ff  <= pulse_in;
            tbit_ff   <= tbit_in;
            wait_ff   <= wait_in;
            level_ff  <= level_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a tick transfer never reports a taken trigger
   a_tick_not_taken: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.mode == MODE_TICK |=> !rsp_data.trigger_taken)
      else $error("tick reported a taken trigger");

   // a taken trigger zeroes the level
   a_taken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trigger_taken |-> rsp_data.drive_level == '0)
      else $error("taken trigger left a nonzero level");

   // no active pattern means the motor is off
   a_idle_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pattern_now == PAT_NONE |-> rsp_data.drive_level == '0)
      else $error("level driven with no pattern");

   // reported pattern is always a known code
   a_pat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pattern_now <= PAT_HIGH)
      else $error("unknown pattern code reported");

endmodule

>>> bench/tb.sv
module tb;
   import hps_pkg::*;

   // directed plan rows: a batch of items or one clamp setting
   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   reps;
      logic         cfg_val;
      req_type      item;
      logic         typed;
      rsp_type      want;
   } plan_row_type;

   localparam int PLAN_ROWS    = 25;
   localparam int PHASE_ITEMS  = 40;
   localparam int LIMIT_CYCLES = 1_000_000;

   // ticks needed to run low power well past its end
   localparam int HAUL_LOW   = RAMP_BASE * 20 + 13 * 15 + 11 * 10 + 30;

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // nothing selected: ticks and plain triggers leave all at zero
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b1, '{8'd0, PAT_NONE, 1'b0}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_NONE, 1'b0}, 1'b1,
        '{8'd0, PAT_NONE, 1'b0}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_NONE, 1'b1}, 1'b1,
        '{8'd0, PAT_NONE, 1'b1}},
      // unknown codes fold to none
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, 3'd7, 1'b0}, 1'b1, '{8'd0, PAT_NONE, 1'b0}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, 3'd5, 1'b1}, 1'b1, '{8'd0, PAT_NONE, 1'b1}},
      // toggle starts low on the first tick, flips after its hold
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_TOGGLE, 1'b0}, 1'b1,
        '{8'd0, PAT_TOGGLE, 1'b1}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b1, '{8'd0, PAT_TOGGLE, 1'b0}},
      '{ROW_ITEM, 8'd50, 1'b0, '{MODE_TICK, 3'd7, 1'b1}, 1'b0, '0},
      // same toggle again: not taken, but the next flip goes back to zero
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_TOGGLE, 1'b0}, 1'b0, '0},
      '{ROW_ITEM, 8'd50, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b0, '0},
      // high power, then a restart of the same pattern
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_HIGH, 1'b0}, 1'b1,
        '{8'd0, PAT_HIGH, 1'b1}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b1, '{8'd150, PAT_HIGH, 1'b0}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_HIGH, 1'b1}, 1'b1,
        '{8'd0, PAT_HIGH, 1'b1}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b1, '{8'd150, PAT_HIGH, 1'b0}},
      '{ROW_ITEM, 8'd60, 1'b0, '{MODE_TICK, PAT_LOW, 1'b1}, 1'b0, '0},
      // unknown code drops the running pattern
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, 3'd6, 1'b0}, 1'b1, '{8'd0, PAT_NONE, 1'b1}},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b1, '{8'd0, PAT_NONE, 1'b0}},
      // low power ramp: small steps raised to the floor, then clamp released mid hold
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_LOW, 1'b1}, 1'b1, '{8'd0, PAT_LOW, 1'b1}},
      '{ROW_ITEM, 8'd21, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b0, '0},
      '{ROW_CFG, 8'd0, 1'b1, '0, 1'b0, '0},
      '{ROW_ITEM, 8'd20, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b0, '0},
      '{ROW_CFG, 8'd0, 1'b0, '0, 1'b0, '0},
      // build ramp start, then back to none
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_BUILD, 1'b0}, 1'b1,
        '{8'd0, PAT_BUILD, 1'b1}},
      '{ROW_ITEM, 8'd101, 1'b0, '{MODE_TICK, PAT_NONE, 1'b0}, 1'b0, '0},
      '{ROW_ITEM, 8'd1, 1'b0, '{MODE_TRIGGER, PAT_NONE, 1'b0}, 1'b1,
        '{8'd0, PAT_NONE, 1'b1}}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    csr_valid = 1'b0;
   logic    csr_data  = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_ready;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fault_count    = 0;
   int random_sent;

   // predicted drive outputs, oldest first
   rsp_type drive_forecast [$];

   // sequencer state as predicted
   logic       low_ok      = 1'b0;
   logic [2:0] cur_pattern = PAT_NONE;
   logic [1:0] cur_phase   = PH_START;
   logic [7:0] ladder      = '0;
   logic [2:0] burst_cnt   = '0;
   logic [1:0] pulse_cnt   = '0;
   logic       pulse_hi    = 1'b0;
   logic [6:0] hold_left   = '0;
   logic [7:0] drive_now   = '0;

   haptic_pattern_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // level with dead-zone clamp, hold stored as ticks minus one
   function automatic void set_level(input int v, input int hold);
      logic [7:0] lv;
      lv = 8'(v);
      if (lv != 8'd0 && lv < 8'd75 && !low_ok) begin
         lv = 8'd75;
      end
      drive_now = lv;
      hold_left = 7'(hold - 1);
   endfunction

   // ceiling of 255 * i / RAMP_BASE
   function automatic int ramp_level(input int i);
      return (255 * i + RAMP_BASE - 1) / RAMP_BASE;
   endfunction

   function automatic void end_pattern();
      cur_pattern = PAT_NONE;
      cur_phase   = PH_START;
      hold_left   = '0;
      drive_now   = '0;
   endfunction

   function automatic void next_pulse();
      if (!pulse_hi) begin
         pulse_hi = 1'b1;
         set_level(150, 58);
      end else begin
         pulse_hi = 1'b0;
         set_level(255, 58);
      end
   endfunction

   // low power and build share the ramp, climb and fall steps
   function automatic void ramp_step(input int ramp_hold, input logic is_build);
      int up_hold;
      up_hold = is_build ? 25 : 15;
      case (cur_phase)
         PH_START: begin
            ladder    = '0;
            cur_phase = PH_RAMP;
            set_level(ramp_level(0), ramp_hold);
         end
         PH_RAMP: begin
            ladder = ladder + 8'd1;
            if (ladder < RAMP_BASE) begin
               set_level(ramp_level(ladder), ramp_hold);
            end else begin
               ladder    = 8'd125;
               cur_phase = PH_UP;
               set_level(125, up_hold);
            end
         end
         PH_UP: begin
            ladder = ladder + 8'd10;
            if (ladder <= 8'd245) begin
               set_level(ladder, up_hold);
            end else begin
               ladder    = 8'd255;
               cur_phase = PH_DOWN;
               set_level(255, is_build ? 25 : 10);
            end
         end
         default: begin
            if (is_build) begin
               ladder = ladder - 8'd10;
               if (ladder >= 8'd145) begin
                  set_level(ladder, 25);
               end else begin
                  ladder    = 8'd125;
                  cur_phase = PH_UP;
                  set_level(125, 25);
               end
            end else begin
               ladder = ladder - 8'd15;
               if (ladder > 8'd100) begin
                  set_level(ladder, 10);
               end else begin
                  end_pattern();
               end
            end
         end
      endcase
   endfunction

   // high power: bursts of three pulses, then a falling tail
   function automatic void burst_step();
      case (cur_phase)
         PH_START: begin
            burst_cnt = '0;
            pulse_cnt = '0;
            pulse_hi  = 1'b0;
            cur_phase = PH_RAMP;
            next_pulse();
         end
         PH_RAMP: begin
            pulse_cnt = pulse_cnt + 2'd1;
            if (pulse_cnt < 2'd3) begin
               next_pulse();
            end else begin
               pulse_cnt = '0;
               burst_cnt = burst_cnt + 3'd1;
               if (burst_cnt < 3'd5) begin
                  pulse_hi = 1'b0;
                  next_pulse();
               end else begin
                  ladder    = 8'd255;
                  cur_phase = PH_UP;
                  set_level(255, 50);
               end
            end
         end
         PH_UP: begin
            ladder = ladder - 8'd10;
            if (ladder >= 8'd10) begin
               set_level(ladder, 50);
            end else begin
               end_pattern();
            end
         end
         default: end_pattern();
      endcase
   endfunction

   // advance the sequencer by one item and return what it drives
   function automatic rsp_type next_drive(input req_type r);
      logic [2:0] p;
      logic       taken;
      taken = 1'b0;
      if (r.mode == MODE_TRIGGER) begin
         p = (r.pattern > PAT_HIGH) ? PAT_NONE : r.pattern;
         if (p == PAT_TOGGLE) begin
            ladder = '0;
         end
         if (cur_pattern != p || r.restart) begin
            taken = 1'b1;
         end
         cur_pattern = p;
         if (taken) begin
            drive_now = '0;
            cur_phase = PH_START;
            hold_left = '0;
         end
      end else if (cur_pattern != PAT_NONE) begin
         if (hold_left != '0) begin
            hold_left = hold_left - 7'd1;
         end else begin
            case (cur_pattern)
               PAT_TOGGLE: begin
                  if (ladder == '0) begin
                     ladder = 8'd1;
                     set_level(0, 50);
                  end else begin
                     ladder = '0;
                     set_level(200, 50);
                  end
               end
               PAT_LOW:   ramp_step(20, 1'b0);
               PAT_BUILD: ramp_step(100, 1'b1);
               PAT_HIGH:  burst_step();
               default: ;
            endcase
         end
      end
      return '{drive_now, cur_pattern, taken};
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(input req_type d, input logic typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      p = next_drive(d);
      drive_forecast.push_back(typed ? want : p);
   endtask

   // ticks carry random pattern and restart bits, which must be ignored
   task automatic send_ticks(input int n);
      repeat (n) begin
         send_item('{MODE_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))});
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (drive_forecast.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_allow(input logic v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      low_ok = v;
      csr_valid <= 1'b0;
   endtask

   // mostly a trigger followed by a run of ticks, sometimes stray items
   task automatic random_burst();
      int      pick;
      int      n;
      req_type d;
      pick = $urandom_range(99);
      if (pick < 70) begin
         d.mode    = MODE_TRIGGER;
         d.pattern = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
         d.restart = 1'($urandom_range(0, 1));
         send_item(d);
         n = ($urandom_range(5) == 0) ? $urandom_range(80, 400) : $urandom_range(1, 80);
         send_ticks(n);
         random_sent += n + 1;
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            send_item(req_type'(5'($urandom_range(0, 31))));
         end
         random_sent += n;
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_forecast.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("unexpected result: level %0d pattern %0d taken %0d",
                        rsp_data.drive_level, rsp_data.pattern_now,
                        rsp_data.trigger_taken);
            end
         end else begin
            want = drive_forecast.pop_front();
            if (rsp_data.drive_level !== want.drive_level
                || rsp_data.pattern_now !== want.pattern_now
                || rsp_data.trigger_taken !== want.trigger_taken) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch exp/got: level %0d/%0d pattern %0d/%0d taken %0d/%0d",
                           want.drive_level, rsp_data.drive_level,
                           want.pattern_now, rsp_data.pattern_now,
                           want.trigger_taken, rsp_data.trigger_taken);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed plan
      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_CFG) begin
            write_allow(PLAN[i].cfg_val);
         end else begin
            repeat (PLAN[i].reps) begin
               send_item(PLAN[i].item, PLAN[i].typed, PLAN[i].want);
            end
         end
      end

      // random phases; the running pattern carries over each clamp change
      for (int ph = 0; ph < 4; ph++) begin
         write_allow(!ph[0]);
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
            default: begin send_idle_pct = 29; recv_stall_pct <= 29; end
         endcase
         random_sent = 0;
         while (random_sent < PHASE_ITEMS) begin
            random_burst();
         end
         // in the first phase, low power followed all the way through
         case (ph)
            0: begin
               send_item('{MODE_TRIGGER, PAT_LOW, 1'b1});
               send_ticks(HAUL_LOW);
            end
            default: ;
         endcase
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_CYCLES * 4);
      $display("Test completed with failures");
      $finish;
   end

endmodule
